@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is checked through reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mfim_pkg.sv @@
// ----------------------------------------------------------------------------
// mfim_pkg
// Types and constants of the matched face index mapper.
// ----------------------------------------------------------------------------
package mfim_pkg;

    // Field widths of the input and result beats.
    localparam int OFFSET_W = 10;
    localparam int INDEX_W  = 32;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Register widths.
    localparam int DIM_W   = 11;
    localparam int START_W = 10;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NI         = 3'd0,
        CFG_NJ         = 3'd1,
        CFG_NK         = 3'd2,
        CFG_FACE_AXIS  = 3'd3,
        CFG_FACE_PLANE = 3'd4,
        CFG_START_A    = 3'd5,
        CFG_START_B    = 3'd6,
        CFG_AXIS_CTRL  = 3'd7
    } t_cfg_idx;

    // Fixed boundary axis codes.
    typedef enum logic [1:0] {
        AXIS_I    = 2'd0,
        AXIS_J    = 2'd1,
        AXIS_K    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // Bit positions in the axis control register.
    localparam int CTRL_SWAP   = 0;
    localparam int CTRL_A_FALL = 1;
    localparam int CTRL_B_FALL = 2;

endpackage

@@ rtl/core/mfim_if.sv @@
// ----------------------------------------------------------------------------
// mfim_in_if / mfim_out_if
// Valid/ready channels for donor face beats and receiver index beats.
// ----------------------------------------------------------------------------
interface mfim_in_if;
    import mfim_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] first_offset;
    logic [OFFSET_W-1:0] second_offset;
    logic                last_in;

    modport source (output valid, first_offset, second_offset, last_in, input ready);
    modport sink   (input valid, first_offset, second_offset, last_in, output ready);
endinterface

interface mfim_out_if;
    import mfim_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] face_index;
    logic               range_error;
    logic               last_out;

    modport source (output valid, face_index, range_error, last_out, input ready);
    modport sink   (input valid, face_index, range_error, last_out, output ready);
endinterface

@@ rtl/core/matched_face_index_mapper.sv @@
// ----------------------------------------------------------------------------
// matched_face_index_mapper
// Maps donor boundary face offsets to receiver global face indexes.
// ----------------------------------------------------------------------------
// The mapper takes one donor face beat per clock unless backpressure from the
// output stalls it, and returns one index beat per face. Stage one swaps
// offsets, forms the free coordinates, checks all ranges and forms pairwise
// count products; stage two holds the multipliers for block face counts and
// strides; stage three sums pairs of terms; stage four adds the halves into
// the output register. Every stage stalls on its own, so bubbles close up
// under backpressure. Configuration writes take effect at once; the user must
// make them only while no face is in flight, as the block does not enforce it.
module matched_face_index_mapper #(
    parameter int MAX_DIM = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mfim_in_if.sink                      i_face,
    mfim_out_if.source                   o_index,
    input  logic                         i_cfg_we,
    input  logic [mfim_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfim_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mfim_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]   r_ni, r_nj, r_nk, r_plane;
    t_axis              r_axis;
    logic [START_W-1:0] r_start_a, r_start_b;
    logic [2:0]         r_ctrl;

    // Stage enables, derived from the back of the pipeline forward.
    logic en1, en2, en3, en4;
    logic r1_valid, r2_valid, r3_valid, r4_valid;

    // A cell count is usable when it is nonzero and no larger than MAX_DIM.
    function automatic logic dim_ok(input logic [DIM_W-1:0] n);
        return (n != '0) && (32'(n) <= 32'(MAX_DIM));
    endfunction

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ni      <= DIM_W'(1);
            r_nj      <= DIM_W'(1);
            r_nk      <= DIM_W'(1);
            r_axis    <= AXIS_I;
            r_plane   <= DIM_W'(1);
            r_start_a <= '0;
            r_start_b <= '0;
            r_ctrl    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NI:         r_ni      <= i_cfg_wdata[DIM_W-1:0];
                CFG_NJ:         r_nj      <= i_cfg_wdata[DIM_W-1:0];
                CFG_NK:         r_nk      <= i_cfg_wdata[DIM_W-1:0];
                CFG_FACE_AXIS:  r_axis    <= t_axis'(i_cfg_wdata[1:0]);
                CFG_FACE_PLANE: r_plane   <= i_cfg_wdata[DIM_W-1:0];
                CFG_START_A:    r_start_a <= i_cfg_wdata[START_W-1:0];
                CFG_START_B:    r_start_b <= i_cfg_wdata[START_W-1:0];
                CFG_AXIS_CTRL:  r_ctrl    <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Handshake chain: a stage loads when it is empty or its successor loads.
    assign en4 = !r4_valid || o_index.ready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_face.ready = en1;

    // ------------------------------------------------------------------
    // Stage 1: coordinates, range checks and pairwise count products.
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] s1_off_a, s1_off_b;
    logic [11:0]         s1_va, s1_vb, s1_nf_p1;
    logic [DIM_W-1:0]    s1_na, s1_nb, s1_nf;
    logic [11:0]         s1_ni_p1, s1_nj_p1;
    logic                s1_ok;

    logic                r1_ok, r1_last;
    t_axis               r1_axis;
    logic [DIM_W-1:0]    r1_a, r1_b, r1_fix, r1_ni, r1_nk;
    logic [22:0]         r1_p1, r1_p2;
    logic [21:0]         r1_p3;

    always_comb begin
        s1_off_a = r_ctrl[CTRL_SWAP] ? i_face.second_offset : i_face.first_offset;
        s1_off_b = r_ctrl[CTRL_SWAP] ? i_face.first_offset  : i_face.second_offset;

        s1_va = r_ctrl[CTRL_A_FALL] ? (12'(r_start_a) - 12'(s1_off_a))
                                    : (12'(r_start_a) + 12'(s1_off_a));
        s1_vb = r_ctrl[CTRL_B_FALL] ? (12'(r_start_b) - 12'(s1_off_b))
                                    : (12'(r_start_b) + 12'(s1_off_b));

        case (r_axis)
            AXIS_I: begin
                s1_nf = r_ni; s1_na = r_nj; s1_nb = r_nk;
            end
            AXIS_J: begin
                s1_nf = r_nj; s1_na = r_ni; s1_nb = r_nk;
            end
            default: begin
                s1_nf = r_nk; s1_na = r_ni; s1_nb = r_nj;
            end
        endcase
        s1_nf_p1 = 12'(s1_nf) + 12'd1;

        s1_ok = dim_ok(r_ni) && dim_ok(r_nj) && dim_ok(r_nk)
             && (r_axis != AXIS_NONE)
             && (r_plane != '0) && (12'(r_plane) <= s1_nf_p1)
             && !s1_va[11] && (s1_va[DIM_W-1:0] < s1_na)
             && !s1_vb[11] && (s1_vb[DIM_W-1:0] < s1_nb);

        s1_ni_p1 = 12'(r_ni) + 12'd1;
        s1_nj_p1 = 12'(r_nj) + 12'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_face.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ok   <= s1_ok;
            r1_last <= i_face.last_in;
            r1_axis <= r_axis;
            r1_a    <= s1_va[DIM_W-1:0];
            r1_b    <= s1_vb[DIM_W-1:0];
            r1_fix  <= r_plane - DIM_W'(1);
            r1_ni   <= r_ni;
            r1_nk   <= r_nk;
            r1_p1   <= 23'(s1_ni_p1) * 23'(r_nj);
            r1_p2   <= 23'(r_ni) * 23'(s1_nj_p1);
            r1_p3   <= 22'(r_ni) * 22'(r_nj);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: block face counts and the three strided terms.
    // ------------------------------------------------------------------
    logic [22:0] s2_mul_b, s2_mul_f;
    logic [11:0] s2_mul_a;

    logic               r2_ok, r2_last;
    t_axis              r2_axis;
    logic [INDEX_W-1:0] r2_cnt_i, r2_cnt_j, r2_term_b, r2_term_f;
    logic [22:0]        r2_term_a;

    always_comb begin
        case (r1_axis)
            AXIS_I: begin
                s2_mul_b = r1_p1;
                s2_mul_f = 23'd1;
                s2_mul_a = 12'(r1_ni) + 12'd1;
            end
            AXIS_J: begin
                s2_mul_b = r1_p2;
                s2_mul_f = 23'(r1_ni);
                s2_mul_a = 12'd1;
            end
            default: begin
                s2_mul_b = 23'(r1_ni);
                s2_mul_f = 23'(r1_p3);
                s2_mul_a = 12'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_ok     <= r1_ok;
            r2_last   <= r1_last;
            r2_axis   <= r1_axis;
            r2_cnt_i  <= INDEX_W'(r1_p1) * INDEX_W'(r1_nk);
            r2_cnt_j  <= INDEX_W'(r1_p2) * INDEX_W'(r1_nk);
            r2_term_b <= INDEX_W'(r1_b) * INDEX_W'(s2_mul_b);
            r2_term_f <= INDEX_W'(r1_fix) * INDEX_W'(s2_mul_f);
            r2_term_a <= 23'(r1_a) * 23'(s2_mul_a);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: base plus fixed-plane term, and the two free-axis terms.
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0] s3_base;

    logic               r3_ok, r3_last;
    logic [INDEX_W-1:0] r3_hi, r3_lo;

    always_comb begin
        case (r2_axis)
            AXIS_I:  s3_base = '0;
            AXIS_J:  s3_base = r2_cnt_i;
            default: s3_base = r2_cnt_i + r2_cnt_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_ok   <= r2_ok;
            r3_last <= r2_last;
            r3_hi   <= s3_base + r2_term_f;
            r3_lo   <= INDEX_W'(r2_term_a) + r2_term_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final sum into the output register.
    // ------------------------------------------------------------------
    logic               r4_err, r4_last;
    logic [INDEX_W-1:0] r4_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en4) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_err   <= !r3_ok;
            r4_last  <= r3_last;
            r4_index <= r3_ok ? (r3_hi + r3_lo) : '0;
        end
    end

    assign o_index.valid       = r4_valid;
    assign o_index.face_index  = r4_index;
    assign o_index.range_error = r4_err;
    assign o_index.last_out    = r4_last;

endmodule

@@ rtl/core/mfim_checker.sv @@
// ----------------------------------------------------------------------------
// mfim_checker
// Port-level assertions for the matched face index mapper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfim_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_index,
    input logic        i_out_err,
    input logic        i_out_last
);

    // A beat held by the consumer keeps its payload.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_index) && $stable(i_out_err) && $stable(i_out_last)), "mfim: stalled result beat changed")

    // A beat flagged with a range error reports index zero.
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, (i_out_valid && i_out_err) |-> (i_out_index == 32'd0), "mfim: range error with nonzero index")

    // With the output register empty the whole pipeline can take a face.
    `ASSERT_CLK(a_ready_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "mfim: input stalled with empty output")

    // Reset empties the pipeline.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "mfim: result beat right after reset")

endmodule

bind matched_face_index_mapper mfim_checker u_mfim_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_face.ready),
    .i_out_valid (o_index.valid),
    .i_out_ready (o_index.ready),
    .i_out_index (o_index.face_index),
    .i_out_err   (o_index.range_error),
    .i_out_last  (o_index.last_out)
);
